/* design/desaturation_event_counter_top_macros.svh */
// Assertion macros used by the desaturation event counter top level.
`ifndef DESATURATION_EVENT_COUNTER_TOP_MACROS_SVH
`define DESATURATION_EVENT_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define DEC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define DEC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/dec_pkg.sv */
// Shared types and constants of the desaturation event counter.
package dec_pkg;

   // Default sizes.
   localparam int WINDOW_MAX_DEF  = 128;
   localparam int MAX_SAMPLES_DEF = 65536;

   // Field widths.
   localparam int SAMPLE_W = 10;
   localparam int EVENT_W  = 17;
   localparam int RATE_W   = 19;
   localparam int RUN_W    = 8;
   localparam int PCT_W    = 7;
   localparam int CSR_W    = 8;
   localparam int CSR_A_W  = 2;

   // Register indexes.
   localparam logic [CSR_A_W-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_TOP_PERCENT   = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_DROP_PERCENT  = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_MIN_RUN       = 2'd3;

   // Reset values of the registers.
   localparam logic [CSR_W-1:0] WINDOW_LENGTH_RST = 8'd60;
   localparam logic [PCT_W-1:0] TOP_PERCENT_RST   = 7'd50;
   localparam logic [PCT_W-1:0] DROP_PERCENT_RST  = 7'd3;
   localparam logic [CSR_W-1:0] MIN_RUN_RST       = 8'd3;

   // Arithmetic constants.
   localparam int PCT          = 100;
   localparam int RATE_SCALE   = 360000;   // 3600 s/h times 100 for hundredths
   localparam int RATE_SCALE_W = 19;
   localparam int RECIP_W      = 16;
   localparam int RECIP_SHIFT  = 22;
   // ceil(2^22 / 100): exact floor(v/100) for v below 2^15
   localparam logic [RECIP_W-1:0] RECIP_100 = 16'd41944;

   localparam logic [EVENT_W-1:0] EVENT_CAP = '1;
   localparam logic [RATE_W-1:0]  RATE_CAP  = '1;
   localparam logic [RUN_W-1:0]   RUN_CAP   = '1;

   // Commands broadcast to every window cell.
   typedef struct packed {
      logic push;        // shift the window by one sample
      logic rank_init;   // copy own sample into the ring, clear rank
      logic rank_step;   // rotate the ring, count larger samples
      logic sum_load;    // load own contribution to the top sum
      logic sum_shift;   // pass contributions toward cell 0
   } cell_ctrl_type;

endpackage

/* design/dec_cell.sv */
// One window cell: holds a sample, ranks it against the ring, feeds the top sum.
module dec_cell #(
   parameter int IDX   = 0,
   parameter int W_W   = 8,
   parameter int IDX_W = 7
) (
   input  logic                          clock,
   input  dec_pkg::cell_ctrl_type        ctrl,
   input  logic [W_W-1:0]                step,
   input  logic [W_W-1:0]                w_eff,
   input  logic [W_W-1:0]                k,
   input  logic [dec_pkg::SAMPLE_W-1:0]  sample_in,
   input  logic [dec_pkg::SAMPLE_W-1:0]  circ_in,
   input  logic [dec_pkg::SAMPLE_W-1:0]  contrib_in,
   output logic [dec_pkg::SAMPLE_W-1:0]  sample_out,
   output logic [dec_pkg::SAMPLE_W-1:0]  circ_out,
   output logic [dec_pkg::SAMPLE_W-1:0]  contrib_out
);

   logic [dec_pkg::SAMPLE_W-1:0] sample_ff;
   logic [dec_pkg::SAMPLE_W-1:0] circ_ff;
   logic [dec_pkg::SAMPLE_W-1:0] contrib_ff;
   logic [IDX_W-1:0]             rank_ff;
   logic                         beats;
   logic                         keep;

   // Incoming sample outranks ours if larger, or equal and from a lower cell
   assign beats = (circ_in > sample_ff) ||
                  ((circ_in == sample_ff) && (step <= W_W'(IDX)));

   // Keep own sample if inside the window and among the k largest
   assign keep = (W_W'(IDX) < w_eff) && (W_W'(rank_ff) < k);

   // Window, ring and sum registers
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         sample_ff <= sample_in;
      end
      if (ctrl.rank_init) begin
         circ_ff <= sample_ff;
         rank_ff <= '0;
      end else if (ctrl.rank_step) begin
         circ_ff <= circ_in;
         if (beats) begin
            rank_ff <= rank_ff + 1'b1;
         end
      end
      if (ctrl.sum_load) begin
         contrib_ff <= keep ? sample_ff : '0;
      end else if (ctrl.sum_shift) begin
         contrib_ff <= contrib_in;
      end
   end

   assign sample_out  = sample_ff;
   assign circ_out    = circ_ff;
   assign contrib_out = contrib_ff;

endmodule

/* design/dec_divider.sv */
// Restoring divider, one quotient bit per cycle.
module dec_divider #(
   parameter int NUM_W = 36,
   parameter int DEN_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W:0]   rem_sh;
   logic             fits;

   // Shift in the next dividend bit and try the subtract
   assign rem_sh = {rem_ff, quo_ff[NUM_W-1]};
   assign fits   = rem_sh >= {1'b0, den};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= num;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= fits ? DEN_W'(rem_sh - {1'b0, den}) : DEN_W'(rem_sh);
            quo_ff <= {quo_ff[NUM_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* design/desaturation_event_counter_top.sv */
// Top level of the desaturation event counter.
// Takes one oximeter sample per beat and returns one result beat per sample.
// Samples sit in a row of WINDOW_MAX cells; the baseline sum of the k largest
// samples in the window is found by rotating a copy of the window through
// the cells to rank each sample and then shifting the kept samples into an
// adder at cell 0. A sample still inside the first W of its recording, where
// W is the effective window length, skips the ranking and the sum. The
// sample marked last adds a one-bit-per-cycle rate division. A new sample is
// taken once the previous one is done, even while its result beat still
// waits for rsp_tready.
`include "desaturation_event_counter_top_macros.svh"

module desaturation_event_counter_top #(
   parameter int WINDOW_MAX  = dec_pkg::WINDOW_MAX_DEF,
   parameter int MAX_SAMPLES = dec_pkg::MAX_SAMPLES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [15:0]                  req_tdata,   // [9:0] sample, rest zero
   input  logic                         req_tlast,   // last sample of recording
   // result channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [39:0]                  rsp_tdata,   // [0] drop_flag, [1] event_start,
                                                     // [18:2] event_count,
                                                     // [37:19] rate_centi, rest zero
   // register write port
   input  logic                         csr_we,
   input  logic [dec_pkg::CSR_A_W-1:0]  csr_addr,
   input  logic [dec_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int W_W   = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W = $clog2(WINDOW_MAX);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = $clog2(WINDOW_MAX * 1023 + 1);
   localparam int WP_W  = W_W + dec_pkg::PCT_W;
   localparam int KP_W  = WP_W + dec_pkg::RECIP_W;
   localparam int LHS_W = SUM_W + dec_pkg::PCT_W;
   localparam int KX_W  = W_W + dec_pkg::SAMPLE_W;
   localparam int RHS_W = KX_W + dec_pkg::PCT_W;
   localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
   localparam int NUM_W = dec_pkg::EVENT_W + dec_pkg::RATE_SCALE_W;

   typedef enum logic [3:0] {
      IDLE, K_MUL, K_SCALE, RANK_INIT, RANK, SUM_LOAD, SUM, MUL, CMP,
      FINISH, DIV_MUL, DIV_GO, DIV_WAIT, OUT
   } state_type;

   state_type state_ff;

   // Registers
   logic [dec_pkg::CSR_W-1:0]    window_length_ff;
   logic [dec_pkg::PCT_W-1:0]    top_percent_ff;
   logic [dec_pkg::PCT_W-1:0]    drop_percent_ff;
   logic [dec_pkg::CSR_W-1:0]    min_run_ff;

   // Per-recording state
   logic [CNT_W-1:0]             sample_count_ff;
   logic [dec_pkg::RUN_W-1:0]    drop_run_ff;
   logic                         armed_ff;
   logic [dec_pkg::EVENT_W-1:0]  events_ff;

   // Working registers
   logic [dec_pkg::SAMPLE_W-1:0] x_ff;
   logic                         last_ff;
   logic [WP_W-1:0]              wp_ff;
   logic [W_W-1:0]               k_ff;
   logic [W_W-1:0]               step_ff;
   logic [SUM_W-1:0]             acc_ff;
   logic [LHS_W-1:0]             lhs_ff;
   logic                         lhs_ok_ff;
   logic [KX_W-1:0]              kx_ff;
   logic                         drop_ff;
   logic                         start_ff;
   logic [NUM_W-1:0]             num_ff;
   logic                         div_start_ff;
   logic [dec_pkg::RATE_W-1:0]   rate_ff;
   logic                         rsp_valid_ff;
   logic [39:0]                  rsp_data_ff;

   // Effective configuration
   logic [W_W-1:0]               w_eff;
   logic [W_W-1:0]               w_m1;
   logic [dec_pkg::PCT_W-1:0]    p_eff;
   logic [dec_pkg::RUN_W-1:0]    r_eff;
   logic                         warm;
   logic [KP_W-1:0]              k_prod;
   logic [CMP_W-1:0]             rhs;
   logic                         drop;
   logic [dec_pkg::RUN_W-1:0]    run_next;
   logic                         armed_next;
   logic                         start_now;

   dec_pkg::cell_ctrl_type       ctrl;
   logic [dec_pkg::SAMPLE_W-1:0] sample_out  [WINDOW_MAX];
   logic [dec_pkg::SAMPLE_W-1:0] circ_out    [WINDOW_MAX];
   logic [dec_pkg::SAMPLE_W-1:0] contrib_out [WINDOW_MAX];
   logic [dec_pkg::SAMPLE_W-1:0] ring_head;

   logic                         div_done;
   logic [NUM_W-1:0]             div_quo;

   // Clamp the registers to their working ranges
   always_comb begin
      if (window_length_ff == '0) begin
         w_eff = W_W'(1);
      end else if (9'(window_length_ff) > 9'(WINDOW_MAX)) begin
         w_eff = W_W'(WINDOW_MAX);
      end else begin
         w_eff = W_W'(window_length_ff);
      end
      if (top_percent_ff == '0) begin
         p_eff = dec_pkg::PCT_W'(1);
      end else if (top_percent_ff > dec_pkg::PCT_W'(dec_pkg::PCT)) begin
         p_eff = dec_pkg::PCT_W'(dec_pkg::PCT);
      end else begin
         p_eff = top_percent_ff;
      end
      r_eff = (min_run_ff == '0) ? dec_pkg::RUN_W'(1) : min_run_ff;
   end

   assign w_m1   = w_eff - 1'b1;
   assign warm   = sample_count_ff >= CNT_W'(w_eff);
   assign k_prod = KP_W'(wp_ff) * KP_W'(dec_pkg::RECIP_100);

   // Drop test and run tracking
   assign rhs        = CMP_W'(kx_ff) * CMP_W'(dec_pkg::PCT);
   assign drop       = lhs_ok_ff && (CMP_W'(lhs_ff) >= rhs);
   assign run_next   = drop ? ((drop_run_ff != dec_pkg::RUN_CAP) ?
                               drop_run_ff + 1'b1 : drop_run_ff) : '0;
   assign armed_next = drop ? armed_ff : 1'b1;
   assign start_now  = (run_next >= r_eff) && armed_next;

   // Cell commands
   always_comb begin
      ctrl.push      = (state_ff == FINISH);
      ctrl.rank_init = (state_ff == RANK_INIT);
      ctrl.rank_step = (state_ff == RANK);
      ctrl.sum_load  = (state_ff == SUM_LOAD);
      ctrl.sum_shift = (state_ff == SUM);
   end

   // Close the ring at the last cell of the window
   assign ring_head = circ_out[w_m1[IDX_W-1:0]];

   // Row of window cells
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic [dec_pkg::SAMPLE_W-1:0] s_in;
      logic [dec_pkg::SAMPLE_W-1:0] c_in;
      logic [dec_pkg::SAMPLE_W-1:0] t_in;
      if (i == 0) begin : g_head
         assign s_in = x_ff;
         assign c_in = ring_head;
      end else begin : g_body
         assign s_in = sample_out[i-1];
         assign c_in = circ_out[i-1];
      end
      if (i == WINDOW_MAX - 1) begin : g_tail
         assign t_in = '0;
      end else begin : g_next
         assign t_in = contrib_out[i+1];
      end
      dec_cell #(
         .IDX   (i),
         .W_W   (W_W),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .step        (step_ff),
         .w_eff       (w_eff),
         .k           (k_ff),
         .sample_in   (s_in),
         .circ_in     (c_in),
         .contrib_in  (t_in),
         .sample_out  (sample_out[i]),
         .circ_out    (circ_out[i]),
         .contrib_out (contrib_out[i])
      );
   end

   // Rate division on the last sample
   dec_divider #(
      .NUM_W (NUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .num      (num_ff),
      .den      (sample_count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= dec_pkg::WINDOW_LENGTH_RST;
         top_percent_ff   <= dec_pkg::TOP_PERCENT_RST;
         drop_percent_ff  <= dec_pkg::DROP_PERCENT_RST;
         min_run_ff       <= dec_pkg::MIN_RUN_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            dec_pkg::CSR_WINDOW_LENGTH: window_length_ff <= csr_wdata;
            dec_pkg::CSR_TOP_PERCENT:   top_percent_ff   <= dec_pkg::PCT_W'(csr_wdata);
            dec_pkg::CSR_DROP_PERCENT:  drop_percent_ff  <= dec_pkg::PCT_W'(csr_wdata);
            dec_pkg::CSR_MIN_RUN:       min_run_ff       <= csr_wdata;
         endcase
      end
   end

   // Sequencer with its registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= IDLE;
         sample_count_ff <= '0;
         drop_run_ff     <= '0;
         armed_ff        <= 1'b1;
         events_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
         div_start_ff    <= 1'b0;
      end else begin
         // pulse the divider start for one cycle
         div_start_ff <= (state_ff == DIV_GO);
         // drop the result beat once taken, unless a new one replaces it
         if (rsp_valid_ff && rsp_tready && (state_ff != OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_tvalid) begin
                  x_ff     <= req_tdata[dec_pkg::SAMPLE_W-1:0];
                  last_ff  <= req_tlast;
                  drop_ff  <= 1'b0;
                  start_ff <= 1'b0;
                  rate_ff  <= '0;
                  state_ff <= K_MUL;
               end
            end
            K_MUL: begin
               wp_ff    <= WP_W'(w_eff) * WP_W'(p_eff) + WP_W'(dec_pkg::PCT - 1);
               state_ff <= K_SCALE;
            end
            K_SCALE: begin
               k_ff     <= W_W'(k_prod >> dec_pkg::RECIP_SHIFT);
               state_ff <= warm ? RANK_INIT : FINISH;
            end
            RANK_INIT: begin
               step_ff  <= W_W'(1);
               state_ff <= (w_eff == W_W'(1)) ? SUM_LOAD : RANK;
            end
            RANK: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == w_m1) begin
                  state_ff <= SUM_LOAD;
               end
            end
            SUM_LOAD: begin
               acc_ff   <= '0;
               step_ff  <= '0;
               state_ff <= SUM;
            end
            SUM: begin
               acc_ff  <= acc_ff + SUM_W'(contrib_out[0]);
               step_ff <= step_ff + 1'b1;
               if (step_ff == w_m1) begin
                  state_ff <= MUL;
               end
            end
            MUL: begin
               lhs_ff    <= LHS_W'(dec_pkg::PCT_W'(dec_pkg::PCT) - drop_percent_ff) *
                            LHS_W'(acc_ff);
               lhs_ok_ff <= (acc_ff != '0) &&
                            (drop_percent_ff <= dec_pkg::PCT_W'(dec_pkg::PCT));
               kx_ff     <= KX_W'(k_ff) * KX_W'(x_ff);
               state_ff  <= CMP;
            end
            CMP: begin
               drop_ff     <= drop;
               drop_run_ff <= run_next;
               start_ff    <= start_now;
               if (start_now) begin
                  armed_ff <= 1'b0;
                  if (events_ff != dec_pkg::EVENT_CAP) begin
                     events_ff <= events_ff + 1'b1;
                  end
               end else begin
                  armed_ff <= armed_next;
               end
               state_ff <= FINISH;
            end
            FINISH: begin
               if (sample_count_ff < CNT_W'(MAX_SAMPLES)) begin
                  sample_count_ff <= sample_count_ff + 1'b1;
               end
               state_ff <= last_ff ? DIV_MUL : OUT;
            end
            DIV_MUL: begin
               num_ff   <= NUM_W'(events_ff) * NUM_W'(dec_pkg::RATE_SCALE);
               state_ff <= DIV_GO;
            end
            DIV_GO: begin
               state_ff <= DIV_WAIT;
            end
            DIV_WAIT: begin
               if (div_done) begin
                  rate_ff  <= (div_quo > NUM_W'(dec_pkg::RATE_CAP)) ?
                              dec_pkg::RATE_CAP : dec_pkg::RATE_W'(div_quo);
                  state_ff <= OUT;
               end
            end
            OUT: begin
               // hold until the result slot is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {2'b00, rate_ff, events_ff, start_ff, drop_ff};
                  rsp_valid_ff <= 1'b1;
                  if (last_ff) begin
                     sample_count_ff <= '0;
                     drop_run_ff     <= '0;
                     armed_ff        <= 1'b1;
                     events_ff       <= '0;
                  end
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   `DEC_ASSERT_IMP(a_start_needs_drop, clock, reset, rsp_valid_ff, !rsp_data_ff[1] || rsp_data_ff[0], "event start without drop")
   `DEC_ASSERT_IMP(a_disarmed_has_run, clock, reset, !armed_ff, drop_run_ff != '0, "disarmed with empty drop run")
   `DEC_ASSERT_IMP(a_rate_only_last, clock, reset, (state_ff == OUT) && !last_ff, rate_ff == '0, "rate set on a non-final sample")
   `DEC_ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready, state_ff == K_MUL, "accepted beat did not start work")

endmodule
